// ----- sv/nlsc_pkg.sv -----
// Package for the noise LFSR sound channel: operation codes, register offsets,
// LFSR constants and the transaction structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nlsc_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  localparam logic [2:0] OFF_ENV  = 3'd1;
  localparam logic [2:0] OFF_POLY = 3'd4;
  localparam logic [2:0] OFF_CTRL = 3'd5;

  localparam int unsigned LFSR_W = 15;

  localparam logic [LFSR_W-1:0] TAP_LONG   = 15'h6000;
  localparam logic [LFSR_W-1:0] TAP_SHORT  = 15'h0060;
  localparam logic [LFSR_W-1:0] SEED_LONG  = 15'h4000;
  localparam logic [LFSR_W-1:0] SEED_SHORT = 15'h0040;

  localparam logic [7:0] LEN_EN_READ = 8'h40;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    op_t        op;
    logic [2:0] reg_offset;
    logic [7:0] write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic signed [7:0] sample_out;
    logic              channel_on;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/noise_lfsr_sound_channel.sv -----
// Top level of the noise LFSR sound channel: input register, channel core and
// result register. Depends on nlsc_pkg and nlsc_core.
//
//   channel   direction  tdata                                  tuser
//   s_axis    in         reg_offset[2:0] write_byte[10:3]       op[1:0]
//   m_axis    out        read_byte[7:0] sample_out[15:8]
//                        channel_on[16]                         -
//
// One transaction per cycle sustained while m_axis does not stall; the input
// is captured in the input register, then the core update is written into the
// result register, which raises m_axis_tvalid.
// The core state and the result register advance together, so a stall on
// m_axis holds the input register and, while it is full, deasserts s_axis_tready.
// rst is synchronous and clears all channel state and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module noise_lfsr_sound_channel (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // reg_offset[2:0], write_byte[10:3], zero pad
  input  wire logic [nlsc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  wire logic [1:0]                        s_axis_tuser,  // op[1:0]
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // read_byte[7:0], sample_out[15:8], channel_on[16], zero pad
  output logic [nlsc_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  logic                 in_valid;
  nlsc_pkg::in_item_t   in_item;
  logic                 out_valid;
  nlsc_pkg::out_item_t  out_item;
  nlsc_pkg::out_item_t  core_result;
  logic                 step;

  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.op         <= nlsc_pkg::op_t'(s_axis_tuser);
      in_item.reg_offset <= s_axis_tdata[2:0];
      in_item.write_byte <= s_axis_tdata[10:3];
    end
  end

  nlsc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_item.channel_on, out_item.sample_out, out_item.read_byte};

endmodule

`default_nettype wire

// ----- sv/nlsc_core.sv -----
// Channel state and single-pass update for one transaction.
// Depends on nlsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nlsc_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire nlsc_pkg::in_item_t  item,
  output nlsc_pkg::out_item_t      result
);

  logic [nlsc_pkg::LFSR_W-1:0] shift_reg, shift_reg_next;
  logic       short_mode, short_mode_next;
  logic [2:0] clock_ratio, clock_ratio_next;
  logic [3:0] clock_shift, clock_shift_next;
  logic [2:0] env_period, env_period_next;
  logic       env_rising, env_rising_next;
  logic [3:0] env_start_volume, env_start_volume_next;
  logic [3:0] env_volume, env_volume_next;
  logic       env_running, env_running_next;
  logic       dac_on, dac_on_next;
  logic       enabled, enabled_next;
  logic       length_enable, length_enable_next;
  logic [7:0] held_sample, held_sample_next;

  logic [7:0] read_data;
  logic [4:0] zvol;
  logic [7:0] mag;
  logic [nlsc_pkg::LFSR_W-1:0] shifted;

  always_comb begin
    shift_reg_next        = shift_reg;
    short_mode_next       = short_mode;
    clock_ratio_next      = clock_ratio;
    clock_shift_next      = clock_shift;
    env_period_next       = env_period;
    env_rising_next       = env_rising;
    env_start_volume_next = env_start_volume;
    env_volume_next       = env_volume;
    env_running_next      = env_running;
    dac_on_next           = dac_on;
    enabled_next          = enabled;
    length_enable_next    = length_enable;
    held_sample_next      = held_sample;
    read_data             = 8'd0;
    zvol                  = {1'b0, env_volume};
    mag                   = {1'b0, env_volume, 3'b000};
    shifted               = {1'b0, shift_reg[nlsc_pkg::LFSR_W-1:1]};

    case (item.op)
      nlsc_pkg::OP_TICK: begin
        if (!enabled) begin
          held_sample_next = 8'd0;
        end else begin
          if (shift_reg[0]) begin
            shift_reg_next = shifted ^ (short_mode ? nlsc_pkg::TAP_SHORT
                                                   : nlsc_pkg::TAP_LONG);
            held_sample_next = mag;
          end else begin
            shift_reg_next   = shifted;
            held_sample_next = 8'd0 - mag;
          end
          if (!dac_on) begin
            held_sample_next = 8'd0;
          end
        end
      end
      nlsc_pkg::OP_WRITE: begin
        case (item.reg_offset)
          nlsc_pkg::OFF_ENV: begin
            env_period_next       = item.write_byte[2:0];
            env_rising_next       = item.write_byte[3];
            env_start_volume_next = item.write_byte[7:4];
            dac_on_next           = item.write_byte[7:3] != 5'd0;
            if (item.write_byte[7:3] == 5'd0) begin
              enabled_next = 1'b0;
            end
            // zombie-mode volume adjustment, using the old period and direction
            if (env_period == 3'd0 && env_running) begin
              zvol = zvol + 5'd1;
            end else if (!env_rising) begin
              zvol = zvol + 5'd2;
            end
            if (env_rising != item.write_byte[3]) begin
              zvol = 5'd16 - zvol;
            end
            env_volume_next = zvol[3:0];
          end
          nlsc_pkg::OFF_POLY: begin
            clock_ratio_next = item.write_byte[2:0];
            short_mode_next  = item.write_byte[3];
            clock_shift_next = item.write_byte[7:4];
          end
          nlsc_pkg::OFF_CTRL: begin
            length_enable_next = item.write_byte[6];
            if (dac_on && item.write_byte[7]) begin
              shift_reg_next   = short_mode ? nlsc_pkg::SEED_SHORT : nlsc_pkg::SEED_LONG;
              enabled_next     = 1'b1;
              env_volume_next  = env_start_volume;
              env_running_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      nlsc_pkg::OP_READ: begin
        case (item.reg_offset)
          nlsc_pkg::OFF_ENV:  read_data = {env_start_volume, env_rising, env_period};
          nlsc_pkg::OFF_POLY: read_data = {clock_shift, short_mode, clock_ratio};
          nlsc_pkg::OFF_CTRL: read_data = length_enable ? nlsc_pkg::LEN_EN_READ : 8'd0;
          default:            read_data = 8'd0;
        endcase
      end
      default: begin
      end
    endcase

    result.read_byte  = read_data;
    result.sample_out = held_sample_next;
    result.channel_on = enabled_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_reg        <= '0;
      short_mode       <= 1'b0;
      clock_ratio      <= 3'd0;
      clock_shift      <= 4'd0;
      env_period       <= 3'd0;
      env_rising       <= 1'b0;
      env_start_volume <= 4'd0;
      env_volume       <= 4'd0;
      env_running      <= 1'b0;
      dac_on           <= 1'b0;
      enabled          <= 1'b0;
      length_enable    <= 1'b0;
      held_sample      <= 8'd0;
    end else if (step) begin
      shift_reg        <= shift_reg_next;
      short_mode       <= short_mode_next;
      clock_ratio      <= clock_ratio_next;
      clock_shift      <= clock_shift_next;
      env_period       <= env_period_next;
      env_rising       <= env_rising_next;
      env_start_volume <= env_start_volume_next;
      env_volume       <= env_volume_next;
      env_running      <= env_running_next;
      dac_on           <= dac_on_next;
      enabled          <= enabled_next;
      length_enable    <= length_enable_next;
      held_sample      <= held_sample_next;
    end
  end

endmodule

`default_nettype wire
